>>> hdl/sbm_pkg.sv
// shared types and constants for the segment phi best-match block
package sbm_pkg;

    // width of a phi difference and the marker for "no match"
    localparam int DIFF_BITS = 8;
    localparam logic [DIFF_BITS-1:0] NO_MATCH = 8'hff;

    // reset value of the match window register
    localparam logic [DIFF_BITS-1:0] MAX_DIFF_RESET = 8'd240;

    // pattern phi is coarse: low bits below it are zero
    localparam int PAT_PHI_SHIFT = 5;
    localparam int PAT_PHI_BITS = 8;

    // record slot code: history in the upper bits, chamber in the lower
    localparam int SLOT_BITS = 4;
    localparam int QUALITY_BITS = 6;
    localparam int PATTERN_BITS = 4;
    localparam int LANES = 2;

    // control from the record stage to the merge stage
    typedef struct packed {
        logic fire;
        logic last;
    } sbm_ctl_t;

    // selection kept by the merge stage
    typedef struct packed {
        logic [DIFF_BITS-1:0] diff;
        logic [1:0]           history;
        logic [1:0]           chamber;
        logic                 segment;
        logic                 seg_valid;
    } sbm_sel_t;

endpackage

>>> hdl/sbm_rec_if.sv
// chamber record channel: valid, ready and one record
interface sbm_rec_if #(
    parameter int PHI_BITS   = 13,
    parameter int THETA_BITS = 7
);
    logic                                valid;
    logic                                ready;
    logic [sbm_pkg::SLOT_BITS-1:0]       slot;
    logic [PHI_BITS-1:0]                 seg_phi_0;
    logic [PHI_BITS-1:0]                 seg_phi_1;
    logic [sbm_pkg::LANES-1:0]           seg_valid;
    logic [THETA_BITS-1:0]               seg_theta_0;
    logic [THETA_BITS-1:0]               seg_theta_1;
    logic [sbm_pkg::PATTERN_BITS-1:0]    seg_pattern_0;
    logic [sbm_pkg::PATTERN_BITS-1:0]    seg_pattern_1;
    logic [sbm_pkg::PAT_PHI_BITS-1:0]    pattern_phi;
    logic [sbm_pkg::QUALITY_BITS-1:0]    pattern_quality;
    logic                                last;

    modport source (
        output valid, slot, seg_phi_0, seg_phi_1, seg_valid, seg_theta_0, seg_theta_1,
               seg_pattern_0, seg_pattern_1, pattern_phi, pattern_quality, last,
        input  ready
    );

    modport sink (
        input  valid, slot, seg_phi_0, seg_phi_1, seg_valid, seg_theta_0, seg_theta_1,
               seg_pattern_0, seg_pattern_1, pattern_phi, pattern_quality, last,
        output ready
    );
endinterface

>>> hdl/sbm_res_if.sv
// match result channel: valid, ready and one chosen segment
interface sbm_res_if #(
    parameter int PHI_BITS   = 13,
    parameter int THETA_BITS = 7
);
    logic                             valid;
    logic                             ready;
    logic                             match_valid;
    logic [1:0]                       history_id;
    logic [1:0]                       chamber_id;
    logic                             segment_id;
    logic [PHI_BITS-1:0]              match_phi;
    logic [THETA_BITS-1:0]            match_theta_0;
    logic [THETA_BITS-1:0]            match_theta_1;
    logic [sbm_pkg::PATTERN_BITS-1:0] match_pattern;

    modport source (
        output valid, match_valid, history_id, chamber_id, segment_id, match_phi,
               match_theta_0, match_theta_1, match_pattern,
        input  ready
    );

    modport sink (
        input  valid, match_valid, history_id, chamber_id, segment_id, match_phi,
               match_theta_0, match_theta_1, match_pattern,
        output ready
    );
endinterface

>>> hdl/sbm_lane.sv
// one segment lane: gated absolute phi difference against the pattern
module sbm_lane #(
    parameter int PHI_BITS = 13
) (
    input  logic [sbm_pkg::DIFF_BITS-1:0] max_phi_diff,
    input  logic [PHI_BITS-1:0]           pattern_phi,
    input  logic [PHI_BITS-1:0]           seg_phi,
    input  logic                          seg_ok,
    input  logic                          pattern_ok,
    output logic [sbm_pkg::DIFF_BITS-1:0] diff
);
    logic [PHI_BITS-1:0] abs_diff;
    logic                too_far;

    // absolute difference
    always_comb
    begin
        if (pattern_phi > seg_phi)
        begin
            abs_diff = pattern_phi - seg_phi;
        end
        else
        begin
            abs_diff = seg_phi - pattern_phi;
        end
    end

    // window check
    assign too_far = abs_diff > PHI_BITS'(max_phi_diff);

    // marker for invalid or out-of-window segments
    always_comb
    begin
        if (!seg_ok || !pattern_ok || too_far)
        begin
            diff = sbm_pkg::NO_MATCH;
        end
        else
        begin
            diff = abs_diff[sbm_pkg::DIFF_BITS-1:0];
        end
    end
endmodule

>>> hdl/sbm_merge.sv
// merge stage: picks the better lane and keeps the running best of the event
module sbm_merge #(
    parameter int PHI_BITS   = 13,
    parameter int THETA_BITS = 7
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  sbm_pkg::sbm_ctl_t                ctl,
    input  logic [sbm_pkg::DIFF_BITS-1:0]    diff_0,
    input  logic [sbm_pkg::DIFF_BITS-1:0]    diff_1,
    input  logic [sbm_pkg::LANES-1:0]        seg_valid,
    input  logic [sbm_pkg::SLOT_BITS-1:0]    slot,
    input  logic [PHI_BITS-1:0]              seg_phi_0,
    input  logic [PHI_BITS-1:0]              seg_phi_1,
    input  logic [THETA_BITS-1:0]            seg_theta_0,
    input  logic [THETA_BITS-1:0]            seg_theta_1,
    input  logic [sbm_pkg::PATTERN_BITS-1:0] seg_pattern_0,
    input  logic [sbm_pkg::PATTERN_BITS-1:0] seg_pattern_1,
    output sbm_pkg::sbm_sel_t                sel,
    output logic [PHI_BITS-1:0]              best_phi,
    output logic [THETA_BITS-1:0]            best_theta_0,
    output logic [THETA_BITS-1:0]            best_theta_1,
    output logic [sbm_pkg::PATTERN_BITS-1:0] best_pattern
);
    logic                             start_reg;
    sbm_pkg::sbm_sel_t                sel_reg;
    sbm_pkg::sbm_sel_t                sel_next;
    logic [PHI_BITS-1:0]              phi_reg;
    logic [PHI_BITS-1:0]              phi_next;
    logic [THETA_BITS-1:0]            theta_0_reg;
    logic [THETA_BITS-1:0]            theta_0_next;
    logic [THETA_BITS-1:0]            theta_1_reg;
    logic [THETA_BITS-1:0]            theta_1_next;
    logic [sbm_pkg::PATTERN_BITS-1:0] pattern_reg;
    logic [sbm_pkg::PATTERN_BITS-1:0] pattern_next;
    logic                             take_1;
    logic [sbm_pkg::DIFF_BITS-1:0]    rec_diff;
    logic                             replace;

    // lane pick: second lane only on a strictly smaller difference
    assign take_1   = diff_1 < diff_0;
    assign rec_diff = take_1 ? diff_1 : diff_0;
    assign replace  = start_reg || (rec_diff < sel_reg.diff);

    // best including this request
    always_comb
    begin
        if (replace)
        begin
            sel_next.diff      = rec_diff;
            sel_next.history   = slot[sbm_pkg::SLOT_BITS-1:2];
            sel_next.chamber   = slot[1:0];
            sel_next.segment   = take_1;
            sel_next.seg_valid = take_1 ? seg_valid[1] : seg_valid[0];
            phi_next           = take_1 ? seg_phi_1 : seg_phi_0;
            pattern_next       = take_1 ? seg_pattern_1 : seg_pattern_0;
            theta_0_next       = seg_theta_0;
            theta_1_next       = seg_theta_1;
        end
        else
        begin
            sel_next     = sel_reg;
            phi_next     = phi_reg;
            pattern_next = pattern_reg;
            theta_0_next = theta_0_reg;
            theta_1_next = theta_1_reg;
        end
    end

    assign sel          = sel_next;
    assign best_phi     = phi_next;
    assign best_theta_0 = theta_0_next;
    assign best_theta_1 = theta_1_next;
    assign best_pattern = pattern_next;

    // event start flag and best selection
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg         <= 1'b1;
            sel_reg.diff      <= sbm_pkg::NO_MATCH;
            sel_reg.history   <= '0;
            sel_reg.chamber   <= '0;
            sel_reg.segment   <= 1'b0;
            sel_reg.seg_valid <= 1'b0;
        end
        else if (ctl.fire)
        begin
            start_reg         <= ctl.last;
            sel_reg.diff      <= ctl.last ? sbm_pkg::NO_MATCH : sel_next.diff;
            sel_reg.history   <= sel_next.history;
            sel_reg.chamber   <= sel_next.chamber;
            sel_reg.segment   <= sel_next.segment;
            sel_reg.seg_valid <= sel_next.seg_valid;
        end
    end

    // best segment payload
    always_ff @(posedge clk)
    begin
        if (ctl.fire)
        begin
            phi_reg     <= phi_next;
            pattern_reg <= pattern_next;
            theta_0_reg <= theta_0_next;
            theta_1_reg <= theta_1_next;
        end
    end

`ifndef SYNTH
    // a closed event always rearms the start flag
    a_start_rearm: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.fire && ctl.last |=> start_reg)
        else $error("start flag not set after last request");

    // the running minimum never grows within an event
    a_min_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.fire && !start_reg |-> sel_next.diff <= sel_reg.diff)
        else $error("running minimum increased");

    // a new event starts from the marker difference
    a_start_marker: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg |-> sel_reg.diff == sbm_pkg::NO_MATCH)
        else $error("event start without marker difference");
`endif
endmodule

>>> hdl/segment_phi_best_match.sv
// top level: two segment lanes, a record stage, the merge stage and a result register
// a last record passes the record stage register, then the merge stage, into the result register
// throughput: one record per cycle when not stalled, both segments side by side
// the only loop is the best-difference compare in the merge stage
// reset: asynchronous, active low; clears the stage valids, arms event start, window 240
// the next record is taken while a result waits, unless a last record would overwrite it
module segment_phi_best_match #(
    parameter int PHI_BITS   = 13,
    parameter int THETA_BITS = 7
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [sbm_pkg::DIFF_BITS-1:0] cfg_wr_data,
    sbm_rec_if.sink                       rec,
    sbm_res_if.source                     res
);
    localparam int PHI_WIDE = PHI_BITS + sbm_pkg::PAT_PHI_BITS + sbm_pkg::PAT_PHI_SHIFT;

    logic [sbm_pkg::DIFF_BITS-1:0]    max_diff_reg;
    logic [PHI_WIDE-1:0]              pat_phi_wide;
    logic [PHI_BITS-1:0]              pat_phi;
    logic                             pat_ok;
    logic [sbm_pkg::DIFF_BITS-1:0]    lane_diff_0;
    logic [sbm_pkg::DIFF_BITS-1:0]    lane_diff_1;
    logic                             rec_fire;
    logic                             merge_fire;
    logic                             res_free;
    sbm_pkg::sbm_ctl_t                merge_ctl;
    sbm_pkg::sbm_sel_t                best_sel;
    logic [PHI_BITS-1:0]              best_phi;
    logic [THETA_BITS-1:0]            best_theta_0;
    logic [THETA_BITS-1:0]            best_theta_1;
    logic [sbm_pkg::PATTERN_BITS-1:0] best_pattern;

    // record stage
    logic                             s1_valid_reg;
    logic                             s1_last_reg;
    logic                             s1_pat_ok_reg;
    logic [sbm_pkg::DIFF_BITS-1:0]    s1_diff_0_reg;
    logic [sbm_pkg::DIFF_BITS-1:0]    s1_diff_1_reg;
    logic [sbm_pkg::LANES-1:0]        s1_seg_valid_reg;
    logic [sbm_pkg::SLOT_BITS-1:0]    s1_slot_reg;
    logic [PHI_BITS-1:0]              s1_phi_0_reg;
    logic [PHI_BITS-1:0]              s1_phi_1_reg;
    logic [THETA_BITS-1:0]            s1_theta_0_reg;
    logic [THETA_BITS-1:0]            s1_theta_1_reg;
    logic [sbm_pkg::PATTERN_BITS-1:0] s1_pattern_0_reg;
    logic [sbm_pkg::PATTERN_BITS-1:0] s1_pattern_1_reg;

    // result register
    logic                             res_valid_reg;
    logic                             res_match_valid_reg;
    logic [1:0]                       res_history_reg;
    logic [1:0]                       res_chamber_reg;
    logic                             res_segment_reg;
    logic [PHI_BITS-1:0]              res_phi_reg;
    logic [THETA_BITS-1:0]            res_theta_0_reg;
    logic [THETA_BITS-1:0]            res_theta_1_reg;
    logic [sbm_pkg::PATTERN_BITS-1:0] res_pattern_reg;

    // match window register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_diff_reg <= sbm_pkg::MAX_DIFF_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_diff_reg <= cfg_wr_data;
        end
    end

    // widened pattern phi and quality gate
    assign pat_phi_wide = PHI_WIDE'({rec.pattern_phi, {sbm_pkg::PAT_PHI_SHIFT{1'b0}}});
    assign pat_phi      = pat_phi_wide[PHI_BITS-1:0];
    assign pat_ok       = rec.pattern_quality != '0;

    // segment lanes
    sbm_lane #(.PHI_BITS(PHI_BITS)) u_lane_0 (
        .max_phi_diff (max_diff_reg),
        .pattern_phi  (pat_phi),
        .seg_phi      (rec.seg_phi_0),
        .seg_ok       (rec.seg_valid[0]),
        .pattern_ok   (pat_ok),
        .diff         (lane_diff_0)
    );

    sbm_lane #(.PHI_BITS(PHI_BITS)) u_lane_1 (
        .max_phi_diff (max_diff_reg),
        .pattern_phi  (pat_phi),
        .seg_phi      (rec.seg_phi_1),
        .seg_ok       (rec.seg_valid[1]),
        .pattern_ok   (pat_ok),
        .diff         (lane_diff_1)
    );

    // flow control
    assign res_free   = !res_valid_reg || res.ready;
    assign merge_fire = s1_valid_reg && (!s1_last_reg || res_free);
    assign rec.ready  = !s1_valid_reg || merge_fire;
    assign rec_fire   = rec.valid && rec.ready;

    // record stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (rec.ready)
        begin
            s1_valid_reg <= rec.valid;
        end
    end

    // record stage payload
    always_ff @(posedge clk)
    begin
        if (rec_fire)
        begin
            s1_last_reg      <= rec.last;
            s1_pat_ok_reg    <= pat_ok;
            s1_diff_0_reg    <= lane_diff_0;
            s1_diff_1_reg    <= lane_diff_1;
            s1_seg_valid_reg <= rec.seg_valid;
            s1_slot_reg      <= rec.slot;
            s1_phi_0_reg     <= rec.seg_phi_0;
            s1_phi_1_reg     <= rec.seg_phi_1;
            s1_theta_0_reg   <= rec.seg_theta_0;
            s1_theta_1_reg   <= rec.seg_theta_1;
            s1_pattern_0_reg <= rec.seg_pattern_0;
            s1_pattern_1_reg <= rec.seg_pattern_1;
        end
    end

    // merge of lanes and running best
    assign merge_ctl.fire = merge_fire;
    assign merge_ctl.last = s1_last_reg;

    sbm_merge #(
        .PHI_BITS   (PHI_BITS),
        .THETA_BITS (THETA_BITS)
    ) u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (merge_ctl),
        .diff_0        (s1_diff_0_reg),
        .diff_1        (s1_diff_1_reg),
        .seg_valid     (s1_seg_valid_reg),
        .slot          (s1_slot_reg),
        .seg_phi_0     (s1_phi_0_reg),
        .seg_phi_1     (s1_phi_1_reg),
        .seg_theta_0   (s1_theta_0_reg),
        .seg_theta_1   (s1_theta_1_reg),
        .seg_pattern_0 (s1_pattern_0_reg),
        .seg_pattern_1 (s1_pattern_1_reg),
        .sel           (best_sel),
        .best_phi      (best_phi),
        .best_theta_0  (best_theta_0),
        .best_theta_1  (best_theta_1),
        .best_pattern  (best_pattern)
    );

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (merge_fire && s1_last_reg)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // result payload, match cleared on zero quality, marker difference or invalid chosen segment
    always_ff @(posedge clk)
    begin
        if (merge_fire && s1_last_reg)
        begin
            res_match_valid_reg <= s1_pat_ok_reg && (best_sel.diff != sbm_pkg::NO_MATCH)
                                   && best_sel.seg_valid;
            res_history_reg     <= best_sel.history;
            res_chamber_reg     <= best_sel.chamber;
            res_segment_reg     <= best_sel.segment;
            res_phi_reg         <= best_phi;
            res_theta_0_reg     <= best_theta_0;
            res_theta_1_reg     <= best_theta_1;
            res_pattern_reg     <= best_pattern;
        end
    end

    assign res.valid         = res_valid_reg;
    assign res.match_valid   = res_match_valid_reg;
    assign res.history_id    = res_history_reg;
    assign res.chamber_id    = res_chamber_reg;
    assign res.segment_id    = res_segment_reg;
    assign res.match_phi     = res_phi_reg;
    assign res.match_theta_0 = res_theta_0_reg;
    assign res.match_theta_1 = res_theta_1_reg;
    assign res.match_pattern = res_pattern_reg;

`ifndef SYNTH
    // an accepted request always lands in the record stage
    a_rec_lands: assert property (@(posedge clk) disable iff (!rst_n)
        rec.valid && rec.ready |=> s1_valid_reg)
        else $error("accepted request lost");

    // a last request held back by a full result register keeps its lanes
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && s1_last_reg && res_valid_reg && !res.ready
        |=> s1_valid_reg && s1_last_reg && $stable(s1_diff_0_reg) && $stable(s1_diff_1_reg))
        else $error("stalled last request changed");

    // a reported match never carries the marker difference
    a_match_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        merge_fire && s1_last_reg && best_sel.diff == sbm_pkg::NO_MATCH
        |=> !res_match_valid_reg)
        else $error("match reported with marker difference");
`endif
endmodule
